// File: design/gdc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gdc_pkg
// shared types, widths and calendar tables for the gregorian date calculator
// ----------------------------------------------------------------------------
package gdc_pkg;

   localparam int ModeWidth     = 3;
   localparam int DayWidth      = 5;
   localparam int MonthWidth    = 4;
   localparam int YearWidth     = 14;
   localparam int ReqDataWidth  = 48;
   localparam int RspDataWidth  = 40;
   localparam int DayNumWidth   = 25;
   localparam int RawDiffWidth  = 26;
   localparam int DiffWidth     = 23;
   localparam int QuotWidth     = 8;
   localparam int RemWidth      = 7;
   localparam int Recip100      = 5243;
   localparam int Recip100Shift = 19;

   typedef enum logic [ModeWidth-1:0] {
      MODE_VALIDATE   = 3'd0,
      MODE_WEEKDAY    = 3'd1,
      MODE_ZODIAC     = 3'd2,
      MODE_DIFFERENCE = 3'd3,
      MODE_PASARAN    = 3'd4
   } mode_type;

   // request data, lowest field last
   typedef struct packed {
      logic [1:0]            pad;
      logic [YearWidth-1:0]  second_year;
      logic [MonthWidth-1:0] second_month;
      logic [DayWidth-1:0]   second_day;
      logic [YearWidth-1:0]  first_year;
      logic [MonthWidth-1:0] first_month;
      logic [DayWidth-1:0]   first_day;
   } req_type;

   // response data, lowest field last
   typedef struct packed {
      logic [5:0]           pad;
      logic [2:0]           pasaran_day;
      logic [DiffWidth-1:0] day_difference;
      logic [3:0]           zodiac_sign;
      logic [2:0]           weekday;
      logic                 date_valid;
   } rsp_type;

   typedef struct packed {
      mode_type              mode;
      logic [DayWidth-1:0]   day;
      logic [MonthWidth-1:0] month;
      logic                  month_ok;
      logic                  second_month_ok;
      logic                  year_nonzero;
   } ctrl_type;

   typedef struct packed {
      logic signed [DayNumWidth-1:0] day_num;
      logic                          leap;
      logic [QuotWidth-1:0]          quot100;
      logic [RemWidth-1:0]           rem100;
   } year_info_type;

   function automatic logic [4:0] month_length(input logic [MonthWidth-1:0] month,
                                               input logic leap);
      logic [4:0] len;
      case (month) inside
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         4'd2: len = leap ? 5'd29 : 5'd28;
         default: len = 5'd0;
      endcase
      return len;
   endfunction

   // days in the months before the given one
   function automatic logic [8:0] cum_days(input logic [MonthWidth-1:0] month,
                                           input logic leap);
      logic [8:0] base;
      case (month)
         4'd1:  base = 9'd0;
         4'd2:  base = 9'd31;
         4'd3:  base = 9'd59;
         4'd4:  base = 9'd90;
         4'd5:  base = 9'd120;
         4'd6:  base = 9'd151;
         4'd7:  base = 9'd181;
         4'd8:  base = 9'd212;
         4'd9:  base = 9'd243;
         4'd10: base = 9'd273;
         4'd11: base = 9'd304;
         4'd12: base = 9'd334;
         default: base = 9'd0;
      endcase
      return base + 9'((leap && (month > 4'd2)) ? 1 : 0);
   endfunction

   // first day of the sign that starts in the given month
   function automatic logic [4:0] sign_start(input logic [MonthWidth-1:0] month);
      logic [4:0] start;
      case (month) inside
         4'd1, 4'd4: start = 5'd20;
         4'd2: start = 5'd19;
         4'd3, 4'd5, 4'd6: start = 5'd21;
         4'd7, 4'd8, 4'd9, 4'd10: start = 5'd23;
         4'd11, 4'd12: start = 5'd22;
         default: start = 5'd0;
      endcase
      return start;
   endfunction

   // floor(13 * (m + 1) / 5) with january and february as months 13 and 14
   function automatic logic [5:0] zeller_month(input logic [MonthWidth-1:0] month);
      logic [5:0] term;
      case (month)
         4'd1:  term = 6'd36;
         4'd2:  term = 6'd39;
         4'd3:  term = 6'd10;
         4'd4:  term = 6'd13;
         4'd5:  term = 6'd15;
         4'd6:  term = 6'd18;
         4'd7:  term = 6'd20;
         4'd8:  term = 6'd23;
         4'd9:  term = 6'd26;
         4'd10: term = 6'd28;
         4'd11: term = 6'd31;
         4'd12: term = 6'd33;
         default: term = 6'd0;
      endcase
      return term;
   endfunction

endpackage
`default_nettype wire

// File: design/gdc_day_number.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gdc_day_number
// four-stage day number of one date, with its leap flag and year / 100 split
// ----------------------------------------------------------------------------
module gdc_day_number (
   input  logic                           clock,
   input  logic                           enable,
   input  logic [gdc_pkg::DayWidth-1:0]   day,
   input  logic [gdc_pkg::MonthWidth-1:0] month,
   input  logic [gdc_pkg::YearWidth-1:0]  year,
   output gdc_pkg::year_info_type         info
);
   import gdc_pkg::*;

   localparam int ProdWidth      = YearWidth + 13;
   localparam int YearDaysWidth  = 23;
   localparam int MonthPartWidth = 10;

   // stage 1
   logic [ProdWidth-1:0]  product;
   logic [QuotWidth-1:0]  quot1_in;
   logic [QuotWidth-1:0]  quot1_ff;
   logic [DayWidth-1:0]   day1_ff;
   logic [MonthWidth-1:0] month1_ff;
   logic [YearWidth-1:0]  year1_ff;

   // stage 2
   logic [YearWidth-1:0]  rem_full;
   logic [RemWidth-1:0]   rem2_in;
   logic                  leap2_in;
   logic [YearWidth-1:0]  ybase2_in;
   logic [QuotWidth-1:0]  ybq2_in;
   logic [RemWidth-1:0]   rem2_ff;
   logic                  leap2_ff;
   logic [YearWidth-1:0]  ybase2_ff;
   logic [QuotWidth-1:0]  ybq2_ff;
   logic [QuotWidth-1:0]  quot2_ff;
   logic [DayWidth-1:0]   day2_ff;
   logic [MonthWidth-1:0] month2_ff;

   // stage 3
   logic [YearDaysWidth-1:0]         year_days3_in;
   logic signed [MonthPartWidth-1:0] month_part3_in;
   logic [YearDaysWidth-1:0]         year_days3_ff;
   logic signed [MonthPartWidth-1:0] month_part3_ff;
   logic                             leap3_ff;
   logic [QuotWidth-1:0]             quot3_ff;
   logic [RemWidth-1:0]              rem3_ff;

   // stage 4
   year_info_type info_in;
   year_info_type info_ff;

   assign product  = ProdWidth'(year) * ProdWidth'(Recip100);
   assign quot1_in = product[Recip100Shift +: QuotWidth];

   always_ff @(posedge clock) begin
      if (enable) begin
         quot1_ff  <= quot1_in;
         day1_ff   <= day;
         month1_ff <= month;
         year1_ff  <= year;
      end
   end

   assign rem_full  = year1_ff - YearWidth'(quot1_ff) * YearWidth'(100);
   assign rem2_in   = rem_full[RemWidth-1:0];
   assign leap2_in  = ((year1_ff[1:0] == 2'b00) && (rem2_in != '0)) ||
                      ((rem2_in == '0) && (quot1_ff[1:0] == 2'b00));
   assign ybase2_in = (year1_ff == '0) ? '0 : year1_ff - YearWidth'(1);
   assign ybq2_in   = (year1_ff == '0) ? '0 :
                      quot1_ff - QuotWidth'((rem2_in == '0) ? 1 : 0);

   always_ff @(posedge clock) begin
      if (enable) begin
         rem2_ff   <= rem2_in;
         leap2_ff  <= leap2_in;
         ybase2_ff <= ybase2_in;
         ybq2_ff   <= ybq2_in;
         quot2_ff  <= quot1_ff;
         day2_ff   <= day1_ff;
         month2_ff <= month1_ff;
      end
   end

   assign year_days3_in = YearDaysWidth'(ybase2_ff) * YearDaysWidth'(365)
                        + YearDaysWidth'(ybase2_ff >> 2)
                        - YearDaysWidth'(ybq2_ff)
                        + YearDaysWidth'(ybq2_ff >> 2);
   assign month_part3_in = MonthPartWidth'(cum_days(month2_ff, leap2_ff))
                         + MonthPartWidth'(day2_ff) - MonthPartWidth'(1);

   always_ff @(posedge clock) begin
      if (enable) begin
         year_days3_ff  <= year_days3_in;
         month_part3_ff <= month_part3_in;
         leap3_ff       <= leap2_ff;
         quot3_ff       <= quot2_ff;
         rem3_ff        <= rem2_ff;
      end
   end

   always_comb begin
      info_in.day_num = $signed(DayNumWidth'(year_days3_ff)) + DayNumWidth'(month_part3_ff);
      info_in.leap    = leap3_ff;
      info_in.quot100 = quot3_ff;
      info_in.rem100  = rem3_ff;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         info_ff <= info_in;
      end
   end

   assign info = info_ff;

endmodule
`default_nettype wire

// File: design/gregorian_date_calculator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gregorian_date_calculator
// validate, weekday, zodiac, day difference and pasaran of gregorian dates
// ----------------------------------------------------------------------------
//  channel | ports    | tuser (low bit up) | tdata (low bit up)
//  --------+----------+--------------------+---------------------------------
//  request | req_*    | mode               | first_day, first_month,
//          |          |                    | first_year, second_day,
//          |          |                    | second_month, second_year
//  result  | rsp_*    | input_error        | date_valid, weekday,
//          |          |                    | zodiac_sign, day_difference,
//          |          |                    | pasaran_day
//
//  one transfer per cycle while the pipe advances; six-register pipe
//  (four day number stages per date, a combine stage, an output stage)
//  the pipe advances when the output register is empty or taken
//  a one-entry skid buffer at the input keeps req_tready a register
//  reset clears the valid bits and the skid buffer
// ----------------------------------------------------------------------------
module gregorian_date_calculator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // first_day, first_month, first_year, second_day, second_month, second_year
   input  logic [gdc_pkg::ReqDataWidth-1:0] req_tdata,
   // mode
   input  logic [gdc_pkg::ModeWidth-1:0]    req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // date_valid, weekday, zodiac_sign, day_difference, pasaran_day
   output logic [gdc_pkg::RspDataWidth-1:0] rsp_tdata,
   // input_error
   output logic                             rsp_tuser
);
   import gdc_pkg::*;

   localparam int ZSumWidth = 11;
   localparam int DiffMax   = 2 ** (DiffWidth - 1) - 1;
   localparam int DiffMin   = -(2 ** (DiffWidth - 1));

   logic en;
   logic accept;

   // input skid buffer
   logic     skid_vld_in;
   logic     skid_vld_ff;
   req_type  skid_req_ff;
   mode_type skid_mode_ff;

   req_type  entry_req;
   mode_type entry_mode;
   logic     entry_vld;
   ctrl_type entry_ctrl;

   logic [6:1] vld_ff;
   ctrl_type   ctrl_ff [1:4];
   ctrl_type   c4;

   year_info_type info1;
   year_info_type info2;

   // combine stage
   logic                     borrow;
   logic [QuotWidth-1:0]     century;
   logic [RemWidth-1:0]      yr_in_cent;
   logic [MonthWidth-1:0]    zodiac_s;
   logic signed [DayNumWidth-1:0] pas_biased;
   logic [23:0]              pas_x;
   logic                     t5_date_ok_in;
   logic [ZSumWidth-1:0]     t5_zsum_in;
   logic [3:0]               t5_zodiac_in;
   logic signed [RawDiffWidth-1:0] t5_diff_in;
   logic [6:0]               t5_pas_sum_in;
   logic                     t5_err_in;
   logic                     t5_date_ok_ff;
   logic [ZSumWidth-1:0]     t5_zsum_ff;
   logic [3:0]               t5_zodiac_ff;
   logic signed [RawDiffWidth-1:0] t5_diff_ff;
   logic [6:0]               t5_pas_sum_ff;
   logic                     t5_err_ff;
   mode_type                 t5_mode_ff;

   // output stage
   logic [4:0]           wk_fold1;
   logic [3:0]           wk_fold2;
   logic [2:0]           weekday_val;
   logic [4:0]           pas_fold;
   logic [2:0]           pas_rem;
   logic [2:0]           pasaran_val;
   logic [DiffWidth-1:0] diff_val;
   rsp_type              rsp_in;
   rsp_type              rsp_ff;
   logic                 input_error_ff;

   assign en         = !vld_ff[6] || rsp_tready;
   assign req_tready = !skid_vld_ff;
   assign accept     = req_tvalid && req_tready;

   assign entry_req  = skid_vld_ff ? skid_req_ff : req_type'(req_tdata);
   assign entry_mode = skid_vld_ff ? skid_mode_ff : mode_type'(req_tuser);
   assign entry_vld  = skid_vld_ff || accept;

   always_comb begin
      entry_ctrl.mode            = entry_mode;
      entry_ctrl.day             = entry_req.first_day;
      entry_ctrl.month           = entry_req.first_month;
      entry_ctrl.month_ok        = (entry_req.first_month >= 4'd1) &&
                                   (entry_req.first_month <= 4'd12);
      entry_ctrl.second_month_ok = (entry_req.second_month >= 4'd1) &&
                                   (entry_req.second_month <= 4'd12);
      entry_ctrl.year_nonzero    = (entry_req.first_year != '0);
   end

   assign skid_vld_in = en ? 1'b0 : (skid_vld_ff || accept);

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_vld_ff <= 1'b0;
         vld_ff      <= '0;
      end else begin
         skid_vld_ff <= skid_vld_in;
         if (en) begin
            vld_ff <= {vld_ff[5:1], entry_vld};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !en) begin
         skid_req_ff  <= req_type'(req_tdata);
         skid_mode_ff <= mode_type'(req_tuser);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctrl_ff[1] <= entry_ctrl;
         for (int i = 2; i <= 4; i++) begin
            ctrl_ff[i] <= ctrl_ff[i-1];
         end
      end
   end

   gdc_day_number u_first (
      .clock  (clock),
      .enable (en),
      .day    (entry_req.first_day),
      .month  (entry_req.first_month),
      .year   (entry_req.first_year),
      .info   (info1)
   );

   gdc_day_number u_second (
      .clock  (clock),
      .enable (en),
      .day    (entry_req.second_day),
      .month  (entry_req.second_month),
      .year   (entry_req.second_year),
      .info   (info2)
   );

   assign c4 = ctrl_ff[4];

   always_comb begin
      t5_date_ok_in = (c4.day != '0) && c4.year_nonzero && c4.month_ok &&
                      (c4.day <= month_length(c4.month, info1.leap));

      // january and february count in the year before
      borrow     = (c4.month < 4'd3);
      century    = info1.quot100 + QuotWidth'(4)
                 - QuotWidth'((borrow && (info1.rem100 == '0)) ? 1 : 0);
      yr_in_cent = !borrow ? info1.rem100 :
                   (info1.rem100 == '0) ? RemWidth'(99) : info1.rem100 - RemWidth'(1);
      t5_zsum_in = ZSumWidth'(c4.day) + ZSumWidth'(zeller_month(c4.month))
                 + ZSumWidth'(yr_in_cent) + ZSumWidth'(yr_in_cent >> 2)
                 + ZSumWidth'(century >> 2) + ZSumWidth'(century) * ZSumWidth'(5);

      zodiac_s     = (5'(c4.day) < sign_start(c4.month)) ? c4.month - 4'd1 : c4.month;
      t5_zodiac_in = (zodiac_s == 4'd12) ? 4'd0 : zodiac_s;

      t5_diff_in = RawDiffWidth'(info2.day_num) - RawDiffWidth'(info1.day_num);

      // 16 is 1 mod 5, so the nibble sum keeps the residue
      pas_biased    = info1.day_num + DayNumWidth'(5);
      pas_x         = pas_biased[23:0];
      t5_pas_sum_in = '0;
      for (int i = 0; i < 6; i++) begin
         t5_pas_sum_in = t5_pas_sum_in + 7'(pas_x[4*i +: 4]);
      end

      unique case (c4.mode) inside
         MODE_WEEKDAY, MODE_ZODIAC, MODE_PASARAN: t5_err_in = !c4.month_ok;
         MODE_DIFFERENCE: t5_err_in = !c4.month_ok || !c4.second_month_ok;
         default: t5_err_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t5_date_ok_ff <= t5_date_ok_in;
         t5_zsum_ff    <= t5_zsum_in;
         t5_zodiac_ff  <= t5_zodiac_in;
         t5_diff_ff    <= t5_diff_in;
         t5_pas_sum_ff <= t5_pas_sum_in;
         t5_err_ff     <= t5_err_in;
         t5_mode_ff    <= c4.mode;
      end
   end

   always_comb begin
      // 8 is 1 mod 7, so octal digit sums keep the residue
      wk_fold1    = 5'(t5_zsum_ff[10:9]) + 5'(t5_zsum_ff[8:6])
                  + 5'(t5_zsum_ff[5:3]) + 5'(t5_zsum_ff[2:0]);
      wk_fold2    = 4'(wk_fold1[4:3]) + 4'(wk_fold1[2:0]);
      weekday_val = (wk_fold2 >= 4'd7) ? 3'(wk_fold2 - 4'd7) : wk_fold2[2:0];

      pas_fold = 5'(t5_pas_sum_ff[6:4]) + 5'(t5_pas_sum_ff[3:0]);
      if (pas_fold >= 5'd20) begin
         pas_rem = 3'(pas_fold - 5'd20);
      end else if (pas_fold >= 5'd15) begin
         pas_rem = 3'(pas_fold - 5'd15);
      end else if (pas_fold >= 5'd10) begin
         pas_rem = 3'(pas_fold - 5'd10);
      end else if (pas_fold >= 5'd5) begin
         pas_rem = 3'(pas_fold - 5'd5);
      end else begin
         pas_rem = pas_fold[2:0];
      end
      pasaran_val = (pas_rem == 3'd0) ? 3'd4 : pas_rem - 3'd1;

      if (t5_diff_ff > RawDiffWidth'(DiffMax)) begin
         diff_val = DiffWidth'(DiffMax);
      end else if (t5_diff_ff < RawDiffWidth'(DiffMin)) begin
         diff_val = DiffWidth'(DiffMin);
      end else begin
         diff_val = t5_diff_ff[DiffWidth-1:0];
      end

      rsp_in = '0;
      if (!t5_err_ff) begin
         unique case (t5_mode_ff)
            MODE_VALIDATE:   rsp_in.date_valid     = t5_date_ok_ff;
            MODE_WEEKDAY:    rsp_in.weekday        = weekday_val;
            MODE_ZODIAC:     rsp_in.zodiac_sign    = t5_zodiac_ff;
            MODE_DIFFERENCE: rsp_in.day_difference = diff_val;
            MODE_PASARAN:    rsp_in.pasaran_day    = pasaran_val;
            default:         rsp_in                = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff         <= rsp_in;
         input_error_ff <= t5_err_ff;
      end
   end

   assign rsp_tvalid = vld_ff[6];
   assign rsp_tdata  = rsp_ff;
   assign rsp_tuser  = input_error_ff;

   a_one_result_field: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($countones({rsp_ff.date_valid, rsp_ff.weekday != '0,
         rsp_ff.zodiac_sign != '0, rsp_ff.day_difference != '0,
         rsp_ff.pasaran_day != '0, input_error_ff}) <= 1))
      else $error("more than one result field set");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_vld_ff && !en) |=> skid_vld_ff)
      else $error("skid entry dropped during stall");

   a_skid_fills: assert property (@(posedge clock) disable iff (reset)
      (accept && !en) |=> skid_vld_ff)
      else $error("stalled transfer not captured");

endmodule
`default_nettype wire
